>>> sv/lsp_pkg.sv
package lsp_pkg;

  // table geometry
  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned TICKET_BITS = 8;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);

  // widths of the item fields
  localparam int unsigned IN_IDX_W  = 6;
  localparam int unsigned IN_TKT_W  = 8;
  localparam int unsigned DRAW_W    = 32;
  localparam int unsigned WIN_W     = 6;
  localparam int unsigned BITCNT_W  = $clog2(DRAW_W);

  // running sums never exceed every entry at full ticket count
  localparam int unsigned TOTAL_W =
    $clog2(ENTRIES * ((1 << TICKET_BITS) - 1) + 1);

  // one ram word: runnable flag above the ticket count
  localparam int unsigned ENTRY_W = TICKET_BITS + 1;

  // stream packing
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 8;

  // item kind carried on the input tuser
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_DRAW   = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic wr;        // write one table entry from the input item
    logic start;     // draw accepted: clear sums, load the random draw
    logic rd_issue;  // read the entry at the address counter, step it
    logic acc;       // add fetched runnable tickets into the total
    logic mod_step;  // one restoring step of draw modulo total
    logic addr_clr;  // rewind the address counter
    logic walk;      // add fetched runnable tickets into the running sum
    logic win_load;  // capture the current fetched entry as winner
    logic set_none;  // record the no-tickets result
    logic out_load;  // move the result into the output register
  } lsp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_addr;   // address counter sits on the last entry
    logic total_zero;  // runnable tickets sum to zero
    logic mod_last;    // final bit of the modulo reduction
    logic found;       // fetched entry pushes the sum past the target
  } lsp_sts_t;

endpackage

>>> sv/lottery_scheduler_pick_unit.sv
// update items are written into the table as they transfer and give no result
// a draw offers its result after a pass over the single-read-port table that sums the
// runnable tickets, a 32-step modulo loop and a second pass that walks to the winner (both
// skipped with no tickets); the input is ready again as the result is offered
// one item is in work at a time; a held result stalls the next draw in its last cycle
// rst_ni clears the controller, output valid and written flags: the table reads as all zero
module lottery_scheduler_pick_unit
  import lsp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_index[5:0], ticket_count[13:6], runnable[14], random_draw[46:15]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // winner_index[5:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // none_runnable[0]
  output logic                 m_axis_tuser
);

  lsp_cmd_t         cmd;
  lsp_sts_t         sts;
  logic [WIN_W-1:0] winner_index;

  lsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .mode_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lsp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .entry_index_i   (s_axis_tdata[5:0]),
    .ticket_count_i  (s_axis_tdata[13:6]),
    .runnable_i      (s_axis_tdata[14]),
    .random_draw_i   (s_axis_tdata[46:15]),
    .winner_index_o  (winner_index),
    .none_runnable_o (m_axis_tuser)
  );

  assign m_axis_tdata = {(M_TDATA_W - WIN_W)'(0), winner_index};

endmodule

>>> sv/lsp_ram.sv
module lsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lsp_dp.sv
module lsp_dp
  import lsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsp_cmd_t            cmd_i,
  output lsp_sts_t            sts_o,
  input  logic [IN_IDX_W-1:0] entry_index_i,
  input  logic [IN_TKT_W-1:0] ticket_count_i,
  input  logic                runnable_i,
  input  logic [DRAW_W-1:0]   random_draw_i,
  output logic [WIN_W-1:0]    winner_index_o,
  output logic                none_runnable_o
);

  logic [ENTRIES-1:0]   ent_vld_q;
  logic                 in_range;
  logic                 ram_we;
  logic [IDX_W-1:0]     waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;

  logic [IDX_W-1:0]     addr_q, addr_d;
  logic [IDX_W-1:0]     idx_q;
  logic                 rd_vld_q;
  logic                 pipe_q;

  logic [TICKET_BITS-1:0] tkt;
  logic                   run;
  logic                   counts;

  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [TOTAL_W-1:0]   sum_q, sum_d;
  logic [TOTAL_W-1:0]   sum_nx;
  logic [TOTAL_W-1:0]   rem_q, rem_d;
  logic [TOTAL_W:0]     trial;
  logic [DRAW_W-1:0]    draw_q, draw_d;
  logic [BITCNT_W-1:0]  bitcnt_q, bitcnt_d;

  logic [WIN_W-1:0]     win_q, win_d;
  logic                 none_q, none_d;
  logic [WIN_W-1:0]     out_win_q;
  logic                 out_none_q;

  // update write into the table
  assign in_range = 32'(entry_index_i) < 32'(ENTRIES);
  assign ram_we   = cmd_i.wr && in_range;
  assign waddr    = IDX_W'(entry_index_i);
  assign wdata    = {runnable_i, TICKET_BITS'(ticket_count_i)};

  lsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // written-entry flags; an unwritten entry reads as zero tickets, idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (ram_we) begin
      ent_vld_q[waddr] <= 1'b1;
    end
  end

  // read pipeline: address counter, fetched index and valid
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.start || cmd_i.addr_clr) begin
      addr_d = '0;
    end else if (cmd_i.rd_issue) begin
      addr_d = addr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      pipe_q   <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      pipe_q   <= cmd_i.rd_issue;
      rd_vld_q <= ent_vld_q[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      idx_q <= addr_q;
    end
  end

  // fetched entry, masked when never written
  assign tkt    = rd_vld_q ? rdata[TICKET_BITS-1:0] : '0;
  assign run    = rd_vld_q & rdata[TICKET_BITS];
  assign counts = pipe_q & run;

  // total of runnable tickets
  always_comb begin
    total_d = total_q;
    if (cmd_i.start) begin
      total_d = '0;
    end else if (cmd_i.acc && counts) begin
      total_d = total_q + TOTAL_W'(tkt);
    end
  end

  // bit-serial restoring reduction of the draw modulo the total
  assign trial = {rem_q, draw_q[DRAW_W-1]};

  always_comb begin
    rem_d    = rem_q;
    draw_d   = draw_q;
    bitcnt_d = bitcnt_q;
    if (cmd_i.start) begin
      rem_d    = '0;
      draw_d   = random_draw_i;
      bitcnt_d = BITCNT_W'(DRAW_W - 1);
    end else if (cmd_i.mod_step) begin
      if (trial >= {1'b0, total_q}) begin
        rem_d = TOTAL_W'(trial - {1'b0, total_q});
      end else begin
        rem_d = trial[TOTAL_W-1:0];
      end
      draw_d   = {draw_q[DRAW_W-2:0], 1'b0};
      bitcnt_d = bitcnt_q - BITCNT_W'(1);
    end
  end

  // running sum during the walk
  assign sum_nx = sum_q + TOTAL_W'(tkt);

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.start) begin
      sum_d = '0;
    end else if (cmd_i.walk && counts) begin
      sum_d = sum_nx;
    end
  end

  // winner capture
  always_comb begin
    win_d  = win_q;
    none_d = none_q;
    if (cmd_i.set_none) begin
      win_d  = '0;
      none_d = 1'b1;
    end else if (cmd_i.win_load) begin
      win_d  = WIN_W'(idx_q);
      none_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q  <= total_d;
    rem_q    <= rem_d;
    draw_q   <= draw_d;
    bitcnt_q <= bitcnt_d;
    sum_q    <= sum_d;
    win_q    <= win_d;
    none_q   <= none_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_win_q  <= win_q;
      out_none_q <= none_q;
    end
  end

  assign winner_index_o  = out_win_q;
  assign none_runnable_o = out_none_q;

  // status; found is only looked at by the controller during the walk
  assign sts_o.last_addr  = (addr_q == IDX_W'(ENTRIES - 1));
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.mod_last   = (bitcnt_q == '0);
  assign sts_o.found      = counts && (sum_nx > rem_q);

endmodule

>>> sv/lsp_ctrl.sv
module lsp_ctrl
  import lsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     mode_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  lsp_sts_t sts_i,
  output lsp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SUM     = 3'd1;
  localparam logic [2:0] ST_SUM_END = 3'd2;
  localparam logic [2:0] ST_CHK     = 3'd3;
  localparam logic [2:0] ST_MOD     = 3'd4;
  localparam logic [2:0] ST_WALK    = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       s_xfer;

  assign s_ready_o = (state_q == ST_IDLE);
  assign s_xfer    = s_valid_i && s_ready_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          if (mode_i == MODE_DRAW) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SUM;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.acc      = 1'b1;
        if (sts_i.last_addr) begin
          state_d = ST_SUM_END;
        end
      end
      ST_SUM_END: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.total_zero) begin
          cmd_o.set_none = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          cmd_o.addr_clr = 1'b1;
          state_d        = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.walk     = 1'b1;
        if (sts_i.found) begin
          cmd_o.win_load = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared by a transfer
  assign m_valid_d = cmd_o.out_load || (m_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule
